// ===== hw/rtl/sed_pkg.sv =====
// Shared types and constants for the sync/escape byte deframer.
package sed_pkg;

  // Byte-wide payload on both stream sides
  localparam int unsigned ByteW = 8;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SYNC   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 1'b1;

  // Register reset values
  localparam logic [ByteW-1:0] SYNC_RESET   = 8'h7E;
  localparam logic [ByteW-1:0] ESCAPE_RESET = 8'h7D;

  // Mask applied to the byte following an escape
  localparam logic [ByteW-1:0] XOR_MASK = 8'h20;

  // Receive mode, one-hot
  typedef enum logic [2:0] {
    MODE_HUNT  = 3'b001,
    MODE_FRAME = 3'b010,
    MODE_ESC   = 3'b100
  } mode_e;

  // Result of one byte transaction, handed to the output register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             last;
    logic             abort;
  } sed_res_t;

endpackage

// ===== hw/rtl/sed_fsm.sv =====
// Framing state machine: hunt, unescape, frame length limit.
module sed_fsm #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [sed_pkg::ByteW-1:0] byte_i,
  input  logic [sed_pkg::ByteW-1:0] sync_i,
  input  logic [sed_pkg::ByteW-1:0] escape_i,
  output sed_pkg::sed_res_t         res_o
);
  import sed_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_FRAME - 1);

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            emit;
  logic            closing;
  logic            cut;
  logic [ByteW-1:0] out_byte;

  // Decode the byte against the current mode
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    closing  = 1'b0;
    out_byte = byte_i;
    case (mode_q)
      MODE_ESC: begin
        emit     = 1'b1;
        out_byte = byte_i ^ XOR_MASK;
      end
      MODE_FRAME: begin
        if (byte_i == escape_i) begin
          mode_d = MODE_ESC;
        end else begin
          emit    = 1'b1;
          closing = (byte_i == sync_i);
        end
      end
      default: begin
        mode_d = (byte_i == sync_i) ? MODE_FRAME : MODE_HUNT;
        cnt_d  = '0;
      end
    endcase

    // Cut the frame off once it reaches the length limit
    cut = emit && !closing && (cnt_q == CntLast);
    if (emit) begin
      if (closing || cut) begin
        mode_d = MODE_HUNT;
        cnt_d  = '0;
      end else begin
        mode_d = MODE_FRAME;
        cnt_d  = cnt_q + 1'b1;
      end
    end

    res_o.valid = emit;
    res_o.data  = out_byte;
    res_o.last  = closing || cut;
    res_o.abort = cut;
  end

  // Advance state only on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // The count is cleared whenever the block hunts
  a_hunt_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HUNT) |-> (cnt_q == '0))
    else $error("frame count not zero while hunting");

  // An escaped byte is always followed by a non-escape mode
  a_esc_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && mode_q == MODE_ESC) |=> (mode_q != MODE_ESC))
    else $error("escape mode held after escaped byte");

  // A byte emitted while escaped never closes a frame normally; it ends one only by a length cut
  a_esc_not_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ESC && res_o.last) |-> res_o.abort)
    else $error("escaped byte closed frame without abort");

endmodule

// ===== hw/rtl/sync_escape_deframer_top.sv =====
// Top level of the sync/escape byte deframer with output register.
// The result of an accepted input byte is registered and appears on m_axis in the cycle after.
// Throughput: one byte per cycle; s_axis_tready is low only while a result
// is held and m_axis_tready is low (single output register).
// Escape bytes that open an escape sequence and bytes outside a frame give no result.
// Reset (rst_ni low, asynchronous) returns to hunting, clears the output
// valid and loads sync 0x7E and escape 0x7D.
module sync_escape_deframer_top #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] in_byte
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
  output logic                        m_axis_tlast,  // frame_end
  output logic                        m_axis_tuser,  // [0] aborted
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [sed_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sed_pkg::ByteW-1:0]   cfg_wdata_i
);
  import sed_pkg::*;

  logic [ByteW-1:0] sync_q;
  logic [ByteW-1:0] escape_q;
  logic             accept;
  sed_res_t         res;
  logic             out_valid_q;
  logic [ByteW-1:0] out_data_q;
  logic             out_last_q;
  logic             out_abort_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= SYNC_RESET;
      escape_q <= ESCAPE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC:   sync_q   <= cfg_wdata_i;
        CFG_ESCAPE: escape_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Take a byte whenever the output register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sed_fsm #(
    .MAX_FRAME (MAX_FRAME)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .sync_i   (sync_q),
    .escape_i (escape_q),
    .res_o    (res)
  );

  // Output valid: set on a new result, drop once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: load with each new result, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      out_data_q  <= res.data;
      out_last_q  <= res.last;
      out_abort_q <= res.abort;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_abort_q;

  // An aborted byte always ends its frame
  a_abort_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("aborted result without frame end");

  // A result with nothing accepted to replace it stays pending under stall
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result lost under stall");

  // Input is never blocked while the output register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

// ===== sim/sync_escape_deframer_top_tb.sv =====
// Self-checking testbench for the sync/escape byte deframer top level.
`timescale 1ns / 100ps

module sync_escape_deframer_top_tb;
  import sed_pkg::*;

  localparam int unsigned FrameMax   = 256;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned MaxReports = 10;

  // One unstuffed byte as it should leave the block
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             abort;
  } frame_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;   // [7:0] out_byte
  logic               m_axis_tlast;   // frame_end
  logic               m_axis_tuser;   // [0] aborted
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ByteW-1:0]   cfg_wdata_i;

  // Shadow of the deframer state and its registers
  mode_e              rx_mode;
  int unsigned        rx_len;
  logic [ByteW-1:0]   sync_cfg;
  logic [ByteW-1:0]   esc_cfg;
  frame_byte_t        unstuffed_q[$];

  int unsigned        errors;
  int unsigned        bytes_sent;
  int unsigned        quiet_cycles;
  int unsigned        src_idle_pct;
  int unsigned        snk_stall_pct;

  sync_escape_deframer_top #(
    .MAX_FRAME(FrameMax)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock: 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= MaxReports) $display("mismatch: %s", msg);
  endfunction

  // Advance the shadow deframer by one received byte, queue any output byte
  function automatic void unstuff_byte(logic [ByteW-1:0] b);
    logic             emit;
    logic             closing;
    logic             cut;
    logic [ByteW-1:0] val;
    emit    = 1'b0;
    closing = 1'b0;
    val     = b;
    case (rx_mode)
      MODE_ESC: begin
        emit = 1'b1;
        val  = b ^ XOR_MASK;
      end
      MODE_FRAME: begin
        if (b == esc_cfg) begin
          rx_mode = MODE_ESC;
        end else begin
          emit    = 1'b1;
          closing = (b == sync_cfg);
        end
      end
      default: begin
        rx_mode = MODE_HUNT;
        if (b == sync_cfg) begin
          rx_mode = MODE_FRAME;
          rx_len  = 0;
        end
      end
    endcase
    if (emit) begin
      cut = !closing && (rx_len + 1 >= FrameMax);
      unstuffed_q.push_back('{data: val, last: closing || cut, abort: cut});
      if (closing || cut) begin
        rx_mode = MODE_HUNT;
        rx_len  = 0;
      end else begin
        rx_mode = MODE_FRAME;
        rx_len  = rx_len + 1;
      end
    end
  endfunction

  // Check output transactions first, then predict from the input transaction
  always @(posedge clk_i) begin : monitor
    frame_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (unstuffed_q.size() == 0) begin
          note_error($sformatf("unexpected byte %02h last %0b abort %0b",
                               m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end else begin
          want = unstuffed_q.pop_front();
          if (want.data !== m_axis_tdata || want.last !== m_axis_tlast ||
              want.abort !== m_axis_tuser)
            note_error($sformatf("expected %02h last %0b abort %0b, got %02h last %0b abort %0b",
                                 want.data, want.last, want.abort,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser));
        end
      end
      if (s_axis_tvalid && s_axis_tready) unstuff_byte(s_axis_tdata);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
  end

  // Send one byte; called and returning at a falling edge, tvalid left high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Drop tvalid, drain all pending output and let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (unstuffed_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SYNC:   sync_cfg = val;
      CFG_ESCAPE: esc_cfg  = val;
      default:    ;
    endcase
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == sync_cfg || b == esc_cfg);
    return b;
  endfunction

  // Framing, escapes and hunting with the reset codes
  task automatic test_basic_frames();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_byte(8'h00);             // dropped while hunting
    send_byte(8'hFF);
    send_byte(ESCAPE_RESET);      // escape outside a frame is dropped
    send_byte(SYNC_RESET);        // open
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ESCAPE_RESET);
    send_byte(8'h5E);             // decodes to sync
    send_byte(ESCAPE_RESET);
    send_byte(8'h5D);             // decodes to escape
    send_byte(ESCAPE_RESET);
    send_byte(SYNC_RESET);        // escaped sync stays data
    send_byte(ESCAPE_RESET);
    send_byte(8'h00);
    send_byte(ESCAPE_RESET);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(SYNC_RESET);        // close
    send_byte(SYNC_RESET);        // empty frame: open then close
    send_byte(SYNC_RESET);
  endtask

  // Frames running into the length limit
  task automatic test_length_limit();
    src_idle_pct  = 13;
    snk_stall_pct = 13;
    // closing sync as byte FrameMax ends normally
    send_byte(sync_cfg);
    repeat (FrameMax - 1) send_byte(plain_byte());
    send_byte(sync_cfg);
    // escaped byte as byte FrameMax is cut off
    send_byte(sync_cfg);
    repeat (FrameMax - 1) send_byte(plain_byte());
    send_byte(esc_cfg);
    send_byte(sync_cfg);
    send_byte(plain_byte());      // hunting again: dropped
  endtask

  // Random frames with random content, some broken, with noise between them
  task automatic run_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned len;
    int unsigned r;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_byte(sync_cfg);
      len = $urandom_range(20, 0);
      for (int unsigned i = 0; i < len; i++) begin
        r = $urandom_range(99, 0);
        if (r < 10) begin
          send_byte(esc_cfg);
          send_byte(8'($urandom_range(255, 0)));
        end else if (r < 15) begin
          send_byte(8'($urandom_range(255, 0)));
        end else begin
          send_byte(plain_byte());
        end
      end
      if ($urandom_range(9, 0) != 0) send_byte(sync_cfg);
      repeat ($urandom_range(3, 0)) send_byte(8'($urandom_range(255, 0)));
    end
  endtask

  // Sync and escape at opposite extremes, first with the sender idling, then with the receiver stalling
  task automatic test_extreme_codes();
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_ESCAPE, 8'hFF);
    src_idle_pct  = 86;
    snk_stall_pct = 0;
    run_random_traffic(45);
    write_reg(CFG_SYNC, 8'hFF);
    write_reg(CFG_ESCAPE, 8'h00);
    src_idle_pct  = 0;
    snk_stall_pct = 86;
    run_random_traffic(45);
  endtask

  // Same value for sync and escape: inside a frame the escape wins
  task automatic test_equal_codes();
    write_reg(CFG_SYNC, 8'h55);
    write_reg(CFG_ESCAPE, 8'h55);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_byte(8'h55);             // opens
    send_byte(8'h55);             // escape
    send_byte(8'h55);             // data 0x75
    send_byte(8'h12);
    send_byte(8'h55);
    send_byte(8'h00);
    run_random_traffic(45);
  endtask

  // Distinct random codes, both sides idling now and then
  task automatic test_random_codes();
    logic [7:0] s;
    logic [7:0] e;
    s = 8'($urandom_range(255, 0));
    do e = 8'($urandom_range(255, 0)); while (e == s);
    write_reg(CFG_SYNC, s);
    write_reg(CFG_ESCAPE, e);
    src_idle_pct  = 13;
    snk_stall_pct = 13;
    run_random_traffic(80);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SYNC;
    cfg_wdata_i   = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    errors        = 0;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    rx_mode       = MODE_HUNT;
    rx_len        = 0;
    sync_cfg      = SYNC_RESET;
    esc_cfg       = ESCAPE_RESET;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_frames();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    run_random_traffic(50);
    test_length_limit();
    test_extreme_codes();
    test_equal_codes();
    test_random_codes();

    // Drain and finish
    settle();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && unstuffed_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sed_pkg.sv
hw/rtl/sed_fsm.sv
hw/rtl/sync_escape_deframer_top.sv
sim/sync_escape_deframer_top_tb.sv
